/* rtl/core/ifx_pkg.sv */
`timescale 1ns / 1ps

package ifx_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int VALUE_BITS  = 32;

    localparam int IDX_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int ENTRY_W = 3;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    localparam logic [31:0] VALUE_MASK = (VALUE_BITS >= 32) ? 32'hFFFF_FFFF :
                                         32'((64'd1 << VALUE_BITS) - 64'd1);

    localparam logic [2:0] ACT_OPERAND = 3'd0;
    localparam logic [2:0] ACT_OPERATOR = 3'd1;
    localparam logic [2:0] ACT_OPEN = 3'd2;
    localparam logic [2:0] ACT_CLOSE = 3'd3;
    localparam logic [2:0] ACT_END = 3'd4;

    localparam logic [ENTRY_W-1:0] OPENER_CODE = 3'd4;

    localparam logic [1:0] KIND_OPERAND = 2'd0;
    localparam logic [1:0] KIND_OPERATOR = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [1:0] ERR_OVERFLOW = 2'd0;
    localparam logic [1:0] ERR_UNMATCHED_CLOSE = 2'd1;
    localparam logic [1:0] ERR_UNMATCHED_OPEN = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
        logic [1:0]  op;
        logic [1:0]  err;
    } res_t;

    typedef struct packed {
        logic push;
        logic done;
    } out_ctrl_t;

endpackage

/* rtl/core/ifx_ram.sv */
`timescale 1ns / 1ps

module ifx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/ifx_seq.sv */
`timescale 1ns / 1ps

module ifx_seq (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ifx_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic [ifx_pkg::S_TUSER_W-1:0]       s_tuser,
    input  logic                                room,
    output ifx_pkg::out_ctrl_t                  ctrl,
    output ifx_pkg::res_t                       res,
    output logic                                ram_we,
    output logic [ifx_pkg::IDX_W-1:0]           ram_waddr,
    output logic [ifx_pkg::ENTRY_W-1:0]         ram_wdata,
    output logic [ifx_pkg::IDX_W-1:0]           ram_raddr,
    input  logic [ifx_pkg::ENTRY_W-1:0]         ram_rdata
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_POP    = 5'b00010,
        ST_PUSH   = 5'b00100,
        ST_EMIT   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t                      state_reg, state_next;
    logic [ifx_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [2:0]                  act_reg, act_next;
    logic [1:0]                  opc_reg, opc_next;
    logic                        seen_reg, seen_next;
    ifx_pkg::res_t               emit_reg, emit_next;

    logic                        top_open;
    logic                        full;
    ifx_pkg::res_t               pop_res;

    assign top_open = (ram_rdata == ifx_pkg::OPENER_CODE);
    assign full     = (count_reg == ifx_pkg::CNT_W'(ifx_pkg::STACK_DEPTH));
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        pop_res.kind  = ifx_pkg::KIND_OPERATOR;
        pop_res.value = '0;
        pop_res.op    = ram_rdata[1:0];
        pop_res.err   = '0;
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        act_next   = act_reg;
        opc_next   = opc_reg;
        seen_next  = seen_reg;
        emit_next  = emit_reg;
        ctrl.push  = 1'b0;
        ctrl.done  = 1'b0;
        res        = emit_reg;
        ram_we     = 1'b0;
        ram_waddr  = count_reg[ifx_pkg::IDX_W-1:0];
        ram_wdata  = (act_reg == ifx_pkg::ACT_OPERATOR) ? {1'b0, opc_reg}
                                                        : ifx_pkg::OPENER_CODE;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    act_next  = s_tuser;
                    opc_next  = s_tdata[33:32];
                    seen_next = 1'b0;
                    unique case (s_tuser)
                        ifx_pkg::ACT_OPERAND: begin
                            emit_next.kind  = ifx_pkg::KIND_OPERAND;
                            emit_next.value = s_tdata[31:0] & ifx_pkg::VALUE_MASK;
                            emit_next.op    = '0;
                            emit_next.err   = '0;
                            state_next      = ST_EMIT;
                        end
                        ifx_pkg::ACT_OPERATOR: begin
                            state_next = (count_reg != '0) ? ST_POP : ST_PUSH;
                        end
                        ifx_pkg::ACT_OPEN: begin
                            state_next = ST_PUSH;
                        end
                        ifx_pkg::ACT_CLOSE: begin
                            emit_next.kind  = ifx_pkg::KIND_ERROR;
                            emit_next.value = '0;
                            emit_next.op    = '0;
                            emit_next.err   = ifx_pkg::ERR_UNMATCHED_CLOSE;
                            state_next      = (count_reg != '0) ? ST_POP : ST_EMIT;
                        end
                        ifx_pkg::ACT_END: begin
                            emit_next.kind  = ifx_pkg::KIND_ERROR;
                            emit_next.value = '0;
                            emit_next.op    = '0;
                            emit_next.err   = ifx_pkg::ERR_UNMATCHED_OPEN;
                            state_next      = (count_reg != '0) ? ST_POP : ST_FINISH;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_POP: begin
                res = pop_res;
                unique case (act_reg)
                    ifx_pkg::ACT_OPERATOR: begin
                        if (top_open || (ram_rdata[1] < opc_reg[1])) begin
                            state_next = ST_PUSH;
                        end else if (room) begin
                            ctrl.push  = 1'b1;
                            count_next = count_reg - 1'b1;
                            if (count_next == '0) begin
                                state_next = ST_PUSH;
                            end
                        end
                    end
                    ifx_pkg::ACT_CLOSE: begin
                        if (top_open) begin
                            count_next = count_reg - 1'b1;
                            state_next = ST_FINISH;
                        end else if (room) begin
                            ctrl.push  = 1'b1;
                            count_next = count_reg - 1'b1;
                            if (count_next == '0) begin
                                state_next = ST_EMIT;
                            end
                        end
                    end
                    default: begin
                        if (top_open) begin
                            seen_next  = 1'b1;
                            count_next = count_reg - 1'b1;
                        end else if (room) begin
                            ctrl.push  = 1'b1;
                            count_next = count_reg - 1'b1;
                        end
                        if (count_next == '0) begin
                            state_next = seen_next ? ST_EMIT : ST_FINISH;
                        end
                    end
                endcase
            end
            ST_PUSH: begin
                if (full) begin
                    emit_next.kind  = ifx_pkg::KIND_ERROR;
                    emit_next.value = '0;
                    emit_next.op    = '0;
                    emit_next.err   = ifx_pkg::ERR_OVERFLOW;
                    state_next      = ST_EMIT;
                end else begin
                    ram_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_EMIT: begin
                if (room) begin
                    ctrl.push  = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (room) begin
                    ctrl.done  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Read the new top every cycle; after a push, FINISH rereads it before IDLE.
    assign ram_raddr = (count_next == '0) ? '0
                                          : ifx_pkg::IDX_W'(count_next - 1'b1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            seen_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            seen_reg  <= seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg  <= act_next;
        opc_reg  <= opc_next;
        emit_reg <= emit_next;
    end

endmodule

/* rtl/core/ifx_out.sv */
`timescale 1ns / 1ps

module ifx_out (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ifx_pkg::out_ctrl_t            ctrl,
    input  ifx_pkg::res_t                 res,
    output logic                          room,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ifx_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [ifx_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                          m_tlast
);

    logic          hold_valid_reg, hold_valid_next;
    ifx_pkg::res_t hold_reg, hold_next;
    logic          m_valid_reg, m_valid_next;
    ifx_pkg::res_t m_reg, m_next;
    logic          m_last_reg, m_last_next;
    logic          m_free;

    assign m_free = !m_valid_reg || m_tready;
    assign room   = !hold_valid_reg || m_free;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_next          = m_reg;
        m_last_next     = m_last_reg;
        if (ctrl.push) begin
            if (hold_valid_reg) begin
                m_next       = hold_reg;
                m_last_next  = 1'b0;
                m_valid_next = 1'b1;
            end
            hold_next       = res;
            hold_valid_next = 1'b1;
        end else if (ctrl.done) begin
            if (hold_valid_reg) begin
                m_next       = hold_reg;
                m_last_next  = 1'b1;
                m_valid_next = 1'b1;
            end
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_reg   <= hold_next;
        m_reg      <= m_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_reg.err, m_reg.op, m_reg.value};
    assign m_tuser  = m_reg.kind;
    assign m_tlast  = m_last_reg;

endmodule

/* rtl/core/infix_to_postfix_converter.sv */
`timescale 1ns / 1ps

// Shunting-yard infix to postfix converter. Each input transaction is one classified
// token; the operator stack lives in a single RAM with one read and one write port, and
// each result leaves through a one-entry hold stage ahead of the output register so the
// final result of a token can carry tlast. One token is processed at a time: an operator
// examines stacked entries, and a closer or end marker pops them, one top entry per cycle
// as the stack RAM delivers it unless output back-pressure stalls the pop; back-pressure
// can stall any token. Undefined actions are dropped. No clearing pass is needed after reset.
module infix_to_postfix_converter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // operand_value[31:0], operator_code[33:32], zero pad
    input  logic [2:0]  s_tuser,   // action[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // token_value[31:0], token_operator[33:32],
                                   // error_code[35:34], zero pad
    output logic [1:0]  m_tuser,   // token_kind[1:0]
    output logic        m_tlast    // last_of_run
);

    ifx_pkg::out_ctrl_t              ctrl;
    ifx_pkg::res_t                   res;
    logic                            room;
    logic                            ram_we;
    logic [ifx_pkg::IDX_W-1:0]       ram_waddr;
    logic [ifx_pkg::ENTRY_W-1:0]     ram_wdata;
    logic [ifx_pkg::IDX_W-1:0]       ram_raddr;
    logic [ifx_pkg::ENTRY_W-1:0]     ram_rdata;

    ifx_ram #(
        .WIDTH(ifx_pkg::ENTRY_W),
        .DEPTH(ifx_pkg::STACK_DEPTH)
    ) u_stack (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    ifx_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .room     (room),
        .ctrl     (ctrl),
        .res      (res),
        .ram_we   (ram_we),
        .ram_waddr(ram_waddr),
        .ram_wdata(ram_wdata),
        .ram_raddr(ram_raddr),
        .ram_rdata(ram_rdata)
    );

    ifx_out u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .res     (res),
        .room    (room),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

/* rtl/core/ifx_checker.sv */
`timescale 1ns / 1ps

module ifx_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // hold a stalled result transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // an error closes its token's run
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ifx_pkg::KIND_ERROR) |-> m_tlast)
        else $error("error result without tlast");

    // an operand is the sole result of its token
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ifx_pkg::KIND_OPERAND) |-> m_tlast
                                                          && (m_tdata[35:32] == 4'd0))
        else $error("operand result malformed");

    // taking a defined token makes the converter busy, so tready drops once it is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && ((s_tuser[2] == 1'b0) || (s_tuser == ifx_pkg::ACT_END))
        |=> !s_tready)
        else $error("input taken while a token is in progress");

endmodule

bind infix_to_postfix_converter ifx_checker u_ifx_checker (.*);

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam logic [1:0] OP_PLUS   = 2'd0;
    localparam logic [1:0] OP_MINUS  = 2'd1;
    localparam logic [1:0] OP_MUL    = 2'd2;
    localparam logic [1:0] OP_DIV    = 2'd3;
    localparam logic [2:0] ACT_RSVD7 = 3'd7;
    localparam int         N_DIRECTED = 13;
    localparam int         RANDOM_ITEMS = 200;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] value;
        logic [1:0]  op;
        logic [1:0]  err;
        logic        last;
    } postfix_tok_t;

    typedef struct {
        logic [2:0]  act;
        logic [31:0] val;
        logic [1:0]  opc;
        int          reps;
        bit          typed;
        int          n_exp;
        logic [1:0]  exp_kind;
        logic [31:0] exp_value;
        logic [1:0]  exp_err;
    } token_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    logic [ifx_pkg::ENTRY_W-1:0] opstack [ifx_pkg::STACK_DEPTH];
    int                          opstack_cnt = 0;
    postfix_tok_t                expected_tokens [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int tokens_sent = 0;
    int tokens_ignored = 0;
    int results_seen = 0;
    int errors_seen = 0;
    int rnd_items = 0;

    token_row_t directed_rows [N_DIRECTED];

    infix_to_postfix_converter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic postfix_tok_t mk_tok(logic [1:0] kind, logic [31:0] value,
                                            logic [1:0] op, logic [1:0] err);
        postfix_tok_t t;
        t.kind  = kind;
        t.value = value;
        t.op    = op;
        t.err   = err;
        t.last  = 1'b0;
        return t;
    endfunction

    function automatic void add_tok(ref postfix_tok_t q [$], input postfix_tok_t t);
        q.insert(q.size(), t);
    endfunction

    // Shunting-yard step: update the operator stack and, if record is set, queue the postfix tokens emitted.
    function automatic void convert_token(logic [2:0] act, logic [31:0] val,
                                          logic [1:0] opc, bit record);
        postfix_tok_t                outs [$];
        logic [ifx_pkg::ENTRY_W-1:0] top;
        bit                          found;
        found = 1'b0;
        case (act)
            ifx_pkg::ACT_OPERAND: begin
                add_tok(outs, mk_tok(ifx_pkg::KIND_OPERAND, val & ifx_pkg::VALUE_MASK,
                                     2'b00, 2'b00));
            end
            ifx_pkg::ACT_OPERATOR: begin
                while (opstack_cnt > 0) begin
                    top = opstack[ifx_pkg::IDX_W'(opstack_cnt - 1)];
                    if (top == ifx_pkg::OPENER_CODE || top[1] < opc[1])
                        break;
                    add_tok(outs, mk_tok(ifx_pkg::KIND_OPERATOR, 32'h0, top[1:0], 2'b00));
                    opstack_cnt--;
                end
                if (opstack_cnt >= ifx_pkg::STACK_DEPTH) begin
                    add_tok(outs, mk_tok(ifx_pkg::KIND_ERROR, 32'h0, 2'b00,
                                         ifx_pkg::ERR_OVERFLOW));
                end else begin
                    opstack[ifx_pkg::IDX_W'(opstack_cnt)] = {1'b0, opc};
                    opstack_cnt++;
                end
            end
            ifx_pkg::ACT_OPEN: begin
                if (opstack_cnt >= ifx_pkg::STACK_DEPTH) begin
                    add_tok(outs, mk_tok(ifx_pkg::KIND_ERROR, 32'h0, 2'b00,
                                         ifx_pkg::ERR_OVERFLOW));
                end else begin
                    opstack[ifx_pkg::IDX_W'(opstack_cnt)] = ifx_pkg::OPENER_CODE;
                    opstack_cnt++;
                end
            end
            ifx_pkg::ACT_CLOSE: begin
                while (opstack_cnt > 0) begin
                    top = opstack[ifx_pkg::IDX_W'(opstack_cnt - 1)];
                    opstack_cnt--;
                    if (top == ifx_pkg::OPENER_CODE) begin
                        found = 1'b1;
                        break;
                    end
                    add_tok(outs, mk_tok(ifx_pkg::KIND_OPERATOR, 32'h0, top[1:0], 2'b00));
                end
                if (!found)
                    add_tok(outs, mk_tok(ifx_pkg::KIND_ERROR, 32'h0, 2'b00,
                                         ifx_pkg::ERR_UNMATCHED_CLOSE));
            end
            ifx_pkg::ACT_END: begin
                while (opstack_cnt > 0) begin
                    top = opstack[ifx_pkg::IDX_W'(opstack_cnt - 1)];
                    opstack_cnt--;
                    if (top == ifx_pkg::OPENER_CODE)
                        found = 1'b1;
                    else
                        add_tok(outs, mk_tok(ifx_pkg::KIND_OPERATOR, 32'h0, top[1:0],
                                             2'b00));
                end
                if (found)
                    add_tok(outs, mk_tok(ifx_pkg::KIND_ERROR, 32'h0, 2'b00,
                                         ifx_pkg::ERR_UNMATCHED_OPEN));
            end
            default: ;
        endcase
        if (outs.size() > 0)
            outs[outs.size() - 1].last = 1'b1;
        if (record)
            foreach (outs[i])
                add_tok(expected_tokens, outs[i]);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch: %s on result %0d, got %0h, want %0h", what, results_seen, got,
                 want);
        mismatches++;
    endtask

    task automatic send_token(logic [2:0] act, logic [31:0] val, logic [1:0] opc,
                              bit predicted);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, opc, val};
        s_tuser  <= act;
        do @(posedge aclk); while (!s_tready);
        convert_token(act, val, opc, predicted);
        if (act > ifx_pkg::ACT_END)
            tokens_ignored++;
        else
            tokens_sent++;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Emit one well-formed expression; a high open_pct can nest past the stack depth.
    task automatic send_expression(int open_pct, int max_len);
        int depth;
        int n;
        int r;
        bit want_operand;
        depth = 0;
        n = 0;
        want_operand = 1'b1;
        forever begin
            if (want_operand) begin
                if ($urandom_range(99) < open_pct && n < max_len) begin
                    send_token(ifx_pkg::ACT_OPEN, $urandom, 2'($urandom_range(3)), 1'b1);
                    depth++;
                end else begin
                    send_token(ifx_pkg::ACT_OPERAND, pick_value(), 2'($urandom_range(3)),
                               1'b1);
                    want_operand = 1'b0;
                end
            end else begin
                r = $urandom_range(9);
                if (n >= max_len && depth == 0) begin
                    break;
                end else if (depth > 0 && (n >= max_len || r < 3)) begin
                    send_token(ifx_pkg::ACT_CLOSE, $urandom, 2'($urandom_range(3)), 1'b1);
                    depth--;
                end else if (depth == 0 && r < 2) begin
                    break;
                end else begin
                    send_token(ifx_pkg::ACT_OPERATOR, $urandom, 2'($urandom_range(3)),
                               1'b1);
                    want_operand = 1'b1;
                end
            end
            n++;
        end
        send_token(ifx_pkg::ACT_END, $urandom, 2'($urandom_range(3)), 1'b1);
        rnd_items += n + 1;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_tokens.size() == 0) begin
                report_mismatch("result with none pending, kind", 32'(m_tuser), 32'h0);
            end else begin
                postfix_tok_t want;
                want = expected_tokens.pop_front();
                if (m_tuser != want.kind)
                    report_mismatch("token_kind", 32'(m_tuser), 32'(want.kind));
                if (m_tdata[31:0] != want.value)
                    report_mismatch("token_value", m_tdata[31:0], want.value);
                if (m_tdata[33:32] != want.op)
                    report_mismatch("token_operator", 32'(m_tdata[33:32]), 32'(want.op));
                if (m_tdata[35:34] != want.err)
                    report_mismatch("error_code", 32'(m_tdata[35:34]), 32'(want.err));
                if (m_tlast != want.last)
                    report_mismatch("last_of_run", 32'(m_tlast), 32'(want.last));
                if (want.kind == ifx_pkg::KIND_ERROR)
                    errors_seen++;
            end
            results_seen++;
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        #5_000_000;
        $display("tb failed");
        $finish;
    end

    initial begin
        token_row_t row;
        int         r;

        directed_rows[0]  = '{ifx_pkg::ACT_OPERAND, 32'h0, OP_PLUS, 1, 1'b1, 1,
                              ifx_pkg::KIND_OPERAND, 32'h0, 2'b00};
        directed_rows[1]  = '{ifx_pkg::ACT_OPERAND, 32'hFFFF_FFFF, OP_DIV, 1, 1'b1, 1,
                              ifx_pkg::KIND_OPERAND, 32'hFFFF_FFFF, 2'b00};
        directed_rows[2]  = '{ifx_pkg::ACT_CLOSE, 32'h0, OP_PLUS, 1, 1'b1, 1,
                              ifx_pkg::KIND_ERROR, 32'h0, ifx_pkg::ERR_UNMATCHED_CLOSE};
        directed_rows[3]  = '{ACT_RSVD7, 32'hFFFF_FFFF, OP_DIV, 1, 1'b1, 0,
                              ifx_pkg::KIND_OPERAND, 32'h0, 2'b00};
        directed_rows[4]  = '{ifx_pkg::ACT_OPERATOR, 32'h0, OP_MINUS, 1, 1'b0, 0,
                              ifx_pkg::KIND_OPERAND, 32'h0, 2'b00};
        directed_rows[5]  = '{ifx_pkg::ACT_OPERATOR, 32'h0, OP_PLUS, 1, 1'b0, 0,
                              ifx_pkg::KIND_OPERAND, 32'h0, 2'b00};
        directed_rows[6]  = '{ifx_pkg::ACT_OPERATOR, 32'h0, OP_DIV, 1, 1'b0, 0,
                              ifx_pkg::KIND_OPERAND, 32'h0, 2'b00};
        directed_rows[7]  = '{ifx_pkg::ACT_OPERATOR, 32'h0, OP_MUL, 1, 1'b0, 0,
                              ifx_pkg::KIND_OPERAND, 32'h0, 2'b00};
        directed_rows[8]  = '{ifx_pkg::ACT_OPEN, 32'h0, OP_PLUS, ifx_pkg::STACK_DEPTH - 3,
                              1'b0, 0, ifx_pkg::KIND_OPERAND, 32'h0, 2'b00};
        directed_rows[9]  = '{ifx_pkg::ACT_OPERATOR, 32'h0, OP_PLUS, 1, 1'b0, 0,
                              ifx_pkg::KIND_OPERAND, 32'h0, 2'b00};
        directed_rows[10] = '{ifx_pkg::ACT_OPERATOR, 32'h0, OP_MUL, 1, 1'b1, 1,
                              ifx_pkg::KIND_ERROR, 32'h0, ifx_pkg::ERR_OVERFLOW};
        directed_rows[11] = '{ifx_pkg::ACT_OPEN, 32'h0, OP_PLUS, 1, 1'b1, 1,
                              ifx_pkg::KIND_ERROR, 32'h0, ifx_pkg::ERR_OVERFLOW};
        directed_rows[12] = '{ifx_pkg::ACT_END, 32'h0, OP_PLUS, 1, 1'b0, 0,
                              ifx_pkg::KIND_OPERAND, 32'h0, 2'b00};

        send_idle_pct = 27;
        recv_idle_pct = 73;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            for (int k = 0; k < row.reps; k++) begin
                send_token(row.act, row.val, row.opc, !row.typed);
                if (row.typed && row.n_exp > 0) begin
                    postfix_tok_t t;
                    t = mk_tok(row.exp_kind, row.exp_value, 2'b00, row.exp_err);
                    t.last = 1'b1;
                    add_tok(expected_tokens, t);
                end
            end
        end

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 73 : 0;
            recv_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 27 : 0;
            while (rnd_items < RANDOM_ITEMS * (phase + 1) / 3) begin
                r = $urandom_range(9);
                if (r < 7) begin
                    send_expression(25, $urandom_range(3, 14));
                end else if (r == 7) begin
                    send_expression(90, $urandom_range(14, 22));
                end else begin
                    repeat ($urandom_range(1, 5)) begin
                        send_token(3'($urandom_range(7)), pick_value(),
                                   2'($urandom_range(3)), 1'b1);
                        rnd_items++;
                    end
                end
            end
        end

        s_tvalid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge aclk);
        repeat (4 * ifx_pkg::STACK_DEPTH + 16) @(posedge aclk);

        $display("sent %0d tokens (%0d undefined actions dropped), checked %0d postfix results",
                 tokens_sent, tokens_ignored, results_seen);
        $display("error results among them: %0d, mismatches: %0d", errors_seen, mismatches);
        if (mismatches == 0 && expected_tokens.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
